// ===== rtl/cdns_pkg.sv =====
package cdns_pkg;

  localparam int MaxDatagramDefault = 496;
  localparam int PosW = 10;
  localparam int CmdDepth = 4;
  localparam int AnsLen = 16;

  localparam logic [PosW-1:0] NameStart = PosW'(12);
  localparam logic [7:0] FlagsHi = 8'h81;
  localparam logic [7:0] FlagsLo = 8'h80;

  // front-to-back command kinds
  localparam logic [1:0] CMD_ECHO   = 2'd0;
  localparam logic [1:0] CMD_ABORT  = 2'd1;
  localparam logic [1:0] CMD_ANSWER = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_abort;
  } tx_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  // answer record after the last class byte: name pointer, type A, class IN,
  // TTL 0, rdlength 4, then the address octets
  function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hc0;
      4'd1:    v = 8'h0c;
      4'd3:    v = 8'h01;
      4'd5:    v = 8'h01;
      4'd11:   v = 8'h04;
      4'd12:   v = addr[31:24];
      4'd13:   v = addr[23:16];
      4'd14:   v = addr[15:8];
      4'd15:   v = addr[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cdns_front.sv =====
module cdns_front
  import cdns_pkg::*;
#(
  parameter int MAX_DATAGRAM = MaxDatagramDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  rx_word_t rx,
  output logic     push,
  output cmd_t     cmd
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_TAIL   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;
  localparam logic [PosW-1:0] PosLimit = PosW'(MAX_DATAGRAM);

  logic [PosW-1:0] pos, pos_next;
  logic [PosW-1:0] nlp, nlp_next;
  logic [1:0]      phase, phase_next;
  logic [1:0]      tcnt, tcnt_next;
  logic [7:0]      q_hi, q_lo;
  logic [PosW-1:0] pos_inc;
  logic [PosW:0]   jump;
  logic            have_cmd;

  assign pos_inc = pos + PosW'(1);
  assign jump    = {1'b0, pos} + {{(PosW-7){1'b0}}, rx.rx_byte} + (PosW+1)'(1);

  always_comb begin
    pos_next   = pos;
    nlp_next   = nlp;
    phase_next = phase;
    tcnt_next  = tcnt;
    have_cmd   = 1'b0;
    cmd.kind   = CMD_ECHO;
    cmd.data   = rx.rx_byte;
    case (phase)
      PH_DONE: begin
        if (rx.rx_last) begin
          pos_next   = '0;
          nlp_next   = NameStart;
          phase_next = PH_HEADER;
          tcnt_next  = '0;
        end
      end
      default: begin
        have_cmd = 1'b1;
        pos_next = pos_inc;
        if (phase == PH_HEADER) begin
          case (pos)
            PosW'(2): cmd.data = FlagsHi;
            PosW'(3): cmd.data = FlagsLo;
            PosW'(6): cmd.data = q_hi;
            PosW'(7): cmd.data = q_lo;
            default: if (pos >= PosW'(8)) cmd.data = 8'h00;
          endcase
          if (pos >= PosW'(11)) phase_next = PH_NAME;
        end else if (phase == PH_NAME) begin
          if (pos == nlp) begin
            if (rx.rx_byte == 8'h00) begin
              phase_next = PH_TAIL;
              tcnt_next  = '0;
            end else begin
              nlp_next = jump[PosW] ? '1 : jump[PosW-1:0];
            end
          end
        end else begin
          tcnt_next = tcnt + 2'd1;
        end

        if (phase == PH_TAIL && tcnt == 2'd3) begin
          // question complete: echo the last class byte, then the answer
          cmd.kind = CMD_ANSWER;
          phase_next = PH_DONE;
        end else if (rx.rx_last || pos_inc >= PosLimit) begin
          cmd.kind   = CMD_ABORT;
          phase_next = PH_DONE;
        end

        if (rx.rx_last && phase_next == PH_DONE) begin
          pos_next   = '0;
          nlp_next   = NameStart;
          phase_next = PH_HEADER;
          tcnt_next  = '0;
        end
      end
    endcase
  end

  assign push = accept && have_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      nlp   <= NameStart;
      phase <= PH_HEADER;
      tcnt  <= '0;
    end else if (accept) begin
      pos   <= pos_next;
      nlp   <= nlp_next;
      phase <= phase_next;
      tcnt  <= tcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_HEADER && pos == PosW'(4)) q_hi <= rx.rx_byte;
    if (accept && phase == PH_HEADER && pos == PosW'(5)) q_lo <= rx.rx_byte;
  end

endmodule

// ===== rtl/cdns_queue.sv =====
module cdns_queue
  import cdns_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  localparam int PtrW = $clog2(CmdDepth);
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            mem [CmdDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full     = (count == CntW'(CmdDepth));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PtrW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/cdns_back.sv =====
module cdns_back
  import cdns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] ap_address,
  input  logic        q_nonempty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        tx_valid,
  input  logic        tx_stall,
  output tx_word_t    tx
);

  logic       out_free;
  logic       burst_on;
  logic [3:0] burst_idx;

  assign out_free = !tx_valid || !tx_stall;
  assign q_pop    = out_free && !burst_on && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid  <= 1'b0;
      burst_on  <= 1'b0;
      burst_idx <= '0;
    end else if (out_free) begin
      if (burst_on) begin
        tx_valid  <= 1'b1;
        burst_idx <= burst_idx + 4'd1;
        if (burst_idx == 4'(AnsLen - 1)) burst_on <= 1'b0;
      end else if (q_nonempty) begin
        tx_valid <= 1'b1;
        if (q_head.kind == CMD_ANSWER) begin
          burst_on  <= 1'b1;
          burst_idx <= '0;
        end
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (burst_on) begin
        tx.tx_byte  <= answer_byte(burst_idx, ap_address);
        tx.tx_last  <= (burst_idx == 4'(AnsLen - 1));
        tx.tx_abort <= 1'b0;
      end else if (q_nonempty) begin
        case (q_head.kind)
          CMD_ABORT: begin
            tx.tx_byte  <= 8'h00;
            tx.tx_last  <= 1'b1;
            tx.tx_abort <= 1'b1;
          end
          default: begin
            tx.tx_byte  <= q_head.data;
            tx.tx_last  <= 1'b0;
            tx.tx_abort <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/captive_dns_responder.sv =====
// Channel  Direction  Handshake           Word
// rx       in         rx_valid/rx_stall   rx_word_t: query byte, last flag
// tx       out        tx_valid/tx_stall   tx_word_t: response byte, last, abort
// cfg      in         cfg_we              cfg_data: answer IPv4 address
//
// One query byte is taken per cycle while rx_stall is low; each echoed or
// rewritten byte passes the command queue and the output register, one
// byte per cycle while tx_stall is low. The final class byte expands into 17
// output bytes; the 4-entry command queue absorbs part, so input may stall.
// Synchronous reset clears parse state, queue, output valid and the address.
// rx_stall is high only while the command queue is full.
module captive_dns_responder
  import cdns_pkg::*;
#(
  parameter int MAX_DATAGRAM = MaxDatagramDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  rx_word_t    rx,
  output logic        tx_valid,
  input  logic        tx_stall,
  output tx_word_t    tx,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  logic [31:0] ap_address;
  logic        rx_accept;
  logic        push;
  cmd_t        cmd;
  logic        q_full;
  logic        q_nonempty;
  logic        q_pop;
  cmd_t        q_head;

  // answer address; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      ap_address <= '0;
    end else if (cfg_we) begin
      ap_address <= cfg_data;
    end
  end

  assign rx_stall  = q_full;
  assign rx_accept = rx_valid && !rx_stall;

  // front: tracks header, label walk and type/class bytes, issues commands
  cdns_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(rx_accept),
    .rx    (rx),
    .push  (push),
    .cmd   (cmd)
  );

  // decouples the byte-per-cycle parser (unless stalled) from the answer burst
  cdns_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(cmd),
    .full    (q_full),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .head    (q_head)
  );

  // back: turns commands into output words, expands the answer record
  cdns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ap_address(ap_address),
    .q_nonempty(q_nonempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx        (tx)
  );

endmodule

// ===== verif/tb_captive_dns_responder.sv =====
`timescale 1ns / 1ps

module tb_captive_dns_responder;
  import cdns_pkg::*;

  localparam int MaxDatagram = MaxDatagramDefault;
  // cycles to let the block settle once nothing more is expected
  localparam int DrainCycles = 32;
  // receiver hold-off that forces the command queue to fill
  localparam int HoldCycles = 300;
  // fixed part of the appended A record: name pointer, type A, class IN,
  // zero TTL, rdlength 4 (address octets follow)
  localparam logic [95:0] AnswerHead = 96'hc00c_0001_0001_0000_0000_0004;

  typedef enum logic [1:0] {PhHeader, PhName, PhTail, PhDone} parse_phase_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  rx_word_t    rx = '0;
  logic        tx_valid;
  logic        tx_stall = 1'b0;
  tx_word_t    tx;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  captive_dns_responder #(
    .MAX_DATAGRAM(MaxDatagram)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx       (rx),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx       (tx),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predictor state: a private copy of the parser and the answer address.
  logic [31:0]  ap_addr;
  logic [9:0]   byte_pos;
  logic [9:0]   label_pos;
  parse_phase_t phase;
  logic [15:0]  qd_count;
  logic [9:0]   tail_cnt;

  // response words still owed by the block, oldest first
  tx_word_t   expected_tx[$];
  // query under construction / being sent
  logic [7:0] dgram[$];

  int mismatch_count = 0;
  int sent_count = 0;
  int hold_left = 0;   // receiver hold-off cycles still to run
  bit quiet = 1'b0;    // no idling on either side

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic tx_word_t word_of(input logic [7:0] b, input logic l, input logic a);
    tx_word_t w;
    w.tx_byte  = b;
    w.tx_last  = l;
    w.tx_abort = a;
    return w;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // back to the start-of-datagram state; the address register is kept
  function automatic void clear_parse();
    byte_pos  = '0;
    label_pos = NameStart;
    phase     = PhHeader;
    qd_count  = '0;
    tail_cnt  = '0;
  endfunction

  // Works out the response words caused by one accepted query word.
  function automatic void predict_response(input logic [7:0] b, input logic l);
    logic [9:0]  p;
    logic [10:0] nl;
    logic [7:0]  v;
    int          k;
    tx_word_t    pend[$];
    p = byte_pos;
    // answer already sent or aborted: swallow until the datagram ends
    if (phase == PhDone) begin
      if (l) clear_parse();
      return;
    end
    case (phase)
      PhHeader: begin
        v = b;
        if (p == 10'd2) v = FlagsHi;
        else if (p == 10'd3) v = FlagsLo;
        else if (p == 10'd4) qd_count[15:8] = b;
        else if (p == 10'd5) qd_count[7:0] = b;
        else if (p == 10'd6) v = qd_count[15:8];
        else if (p == 10'd7) v = qd_count[7:0];
        else if (p >= 10'd8) v = 8'h00;
        pend.push_back(word_of(v, 1'b0, 1'b0));
        if (p >= 10'd11) phase = PhName;
      end
      PhName: begin
        pend.push_back(word_of(b, 1'b0, 1'b0));
        if (p == label_pos) begin
          if (b == 8'h00) begin
            phase    = PhTail;
            tail_cnt = '0;
          end else begin
            // next length byte; saturates when the jump runs off the end
            nl = 11'(p) + 11'(b) + 11'd1;
            label_pos = (nl > 11'd1023) ? 10'd1023 : nl[9:0];
          end
        end
      end
      default: begin
        pend.push_back(word_of(b, 1'b0, 1'b0));
        tail_cnt = tail_cnt + 10'd1;
        if (tail_cnt >= 10'd4) begin
          // last class byte: append the A record
          for (k = 0; k < 12; k++)
            pend.push_back(word_of(AnswerHead[95-8*k -: 8], 1'b0, 1'b0));
          pend.push_back(word_of(ap_addr[31:24], 1'b0, 1'b0));
          pend.push_back(word_of(ap_addr[23:16], 1'b0, 1'b0));
          pend.push_back(word_of(ap_addr[15:8], 1'b0, 1'b0));
          pend.push_back(word_of(ap_addr[7:0], 1'b1, 1'b0));
          if (l) begin
            clear_parse();
          end else begin
            phase    = PhDone;
            byte_pos = p + 10'd1;
          end
          foreach (pend[i]) expected_tx.push_back(pend[i]);
          return;
        end
      end
    endcase
    p = p + 10'd1;
    byte_pos = p;
    // datagram ended early or ran past the size limit: a lone abort word
    if (l || p >= MaxDatagram) begin
      pend.delete();
      pend.push_back(word_of(8'h00, 1'b1, 1'b1));
      if (l) clear_parse();
      else phase = PhDone;
    end
    foreach (pend[i]) expected_tx.push_back(pend[i]);
  endfunction

  // Offer one query word from the falling edge until it is taken.
  task automatic send_word(input logic [7:0] b, input logic l);
    @(negedge clk);
    rx_valid <= 1'b1;
    rx       <= '{rx_byte: b, rx_last: l};
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    sent_count++;
    predict_response(b, l);
  endtask

  // occasional idle burst on the sending side
  task automatic sender_gap();
    int n;
    if (quiet || $urandom_range(0, 7) != 0) return;
    n = $urandom_range(1, 14);
    @(negedge clk);
    rx_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_dgram();
    int k;
    for (k = 0; k < dgram.size(); k++) begin
      send_word(dgram[k], k == dgram.size() - 1);
      sender_gap();
    end
  endtask

  // Sender stops; wait for every owed word, then let the pipe go quiet.
  task automatic wait_drain();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (expected_tx.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_ap_address(input logic [31:0] addr);
    wait_drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(negedge clk);
    cfg_we   <= 1'b0;
    ap_addr = addr;
  endtask

  // Well-formed query: random header, 0..3 labels, root, type/class,
  // then the given number of trailing bytes.
  function automatic void build_query(input int trailing);
    int nlab;
    int len;
    dgram.delete();
    repeat (12) dgram.push_back(rand_byte());
    nlab = $urandom_range(0, 3);
    repeat (nlab) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      dgram.push_back(8'(len));
      repeat (len) dgram.push_back(rand_byte());
    end
    dgram.push_back(8'h00);
    repeat (4 + trailing) dgram.push_back(rand_byte());
  endfunction

  // Header extremes; root name; datagram ends on the last class byte, so
  // the answer completes on rx_last. Address still at its reset value.
  task automatic test_header_rewrite();
    dgram = {8'hff, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'h12, 8'h34,
             8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
    send_dgram();
    wait_drain();
  endtask

  // Datagrams that end inside the header: one byte, then six.
  task automatic test_short_datagram();
    dgram = {8'h55};
    send_dgram();
    dgram = {8'h00, 8'hff, 8'h01, 8'h00, 8'h00, 8'h01};
    send_dgram();
    wait_drain();
  endtask

  // Answer with an all-ones address, then bytes past the question that
  // must be dropped, the closing one too.
  task automatic test_trailing_bytes();
    write_ap_address(32'hffff_ffff);
    dgram = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h00,
             8'h00, 8'h01, 8'h00, 8'h01, 8'haa, 8'h55};
    send_dgram();
    wait_drain();
  endtask

  // Two 255-byte labels push the next length byte past the size limit;
  // the block aborts on the last counted byte and drops the rest.
  task automatic test_oversized_datagram();
    dgram.delete();
    repeat (12) dgram.push_back(rand_byte());
    dgram.push_back(8'hff);
    repeat (255) dgram.push_back(rand_byte());
    dgram.push_back(8'hff);
    while (dgram.size() < MaxDatagram + 2) dgram.push_back(rand_byte());
    send_dgram();
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering: the command queue
  // fills and rx_stall has to hold the input.
  task automatic test_backpressure_fill();
    write_ap_address(32'hc0a8_0401);
    quiet = 1'b1;
    hold_left = HoldCycles;
    build_query(0);
    send_dgram();
    build_query(3);
    send_dgram();
    wait_drain();
    quiet = 1'b0;
  endtask

  // Mostly well-formed queries with random content, the rest truncated
  // queries and raw noise. Four address settings; the last segment runs
  // with no idling on either side.
  task automatic test_random_traffic();
    int seg;
    int start;
    int kind;
    int cut;
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: write_ap_address($urandom);
        1: write_ap_address(32'h0000_0000);
        2: write_ap_address(32'hffff_ffff);
        default: write_ap_address($urandom);
      endcase
      quiet = (seg == 3);
      start = sent_count;
      while (sent_count - start < 20) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          build_query(($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
        end else if (kind < 92) begin
          // cut anywhere before the last class byte
          build_query(0);
          cut = $urandom_range(1, dgram.size() - 1);
          repeat (cut) void'(dgram.pop_back());
        end else begin
          dgram.delete();
          repeat ($urandom_range(1, 48)) dgram.push_back(rand_byte());
        end
        send_dgram();
      end
    end
  endtask

  // Receiver side: long hold-off when asked, else random stall bursts.
  initial begin : tx_stall_gen
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        tx_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        tx_stall <= 1'b0;
      end else if (burst > 0) begin
        tx_stall <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 7) == 0) begin
        tx_stall <= 1'b1;
        burst = $urandom_range(0, 13);
      end else begin
        tx_stall <= 1'b0;
      end
    end
  end

  // Every accepted response word is checked against the oldest owed one.
  initial begin : tx_checker
    tx_word_t want;
    forever begin
      @(posedge clk);
      if (!rst && tx_valid && !tx_stall) begin
        if (expected_tx.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected tx word, expected none, actual %h/%b/%b",
                   $time, tx.tx_byte, tx.tx_last, tx.tx_abort);
        end else begin
          want = expected_tx.pop_front();
          if (tx.tx_byte !== want.tx_byte || tx.tx_last !== want.tx_last ||
              tx.tx_abort !== want.tx_abort) begin
            mismatch_count++;
            $display("%0t: tx mismatch, expected %h/%b/%b, actual %h/%b/%b",
                     $time, want.tx_byte, want.tx_last, want.tx_abort,
                     tx.tx_byte, tx.tx_last, tx.tx_abort);
          end
        end
      end
    end
  end

  initial begin
    ap_addr = '0;
    clear_parse();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_header_rewrite();
    test_short_datagram();
    test_trailing_bytes();
    test_oversized_datagram();
    test_backpressure_fill();
    test_random_traffic();
    wait_drain();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
